// ===== src/tlb_lru_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_pkg: shared types and constants for the TLB lookup block
// Holds field widths, default geometry, the age limit and result status codes.
// ----------------------------------------------------------------------------
package tlb_lru_pkg;

    // default geometry
    localparam int TLB_ENTRIES_DEF = 4;
    localparam int OFFSET_BITS_DEF = 12;

    // fixed field widths
    localparam int ADDR_W  = 16;
    localparam int PPAGE_W = 4;
    localparam int AGE_W   = 2;
    localparam int STAT_W  = 2;

    // input and output stream data widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // saturating age limit, also the reset age
    localparam logic [AGE_W-1:0] AGE_MAX = 2'd3;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STATUS_HIT   = 2'd0,
        STATUS_FILL  = 2'd1,
        STATUS_FAULT = 2'd2
    } status_t;

endpackage

// ===== src/tlb_lookup_lru_fill.sv =====
// ----------------------------------------------------------------------------
// tlb_lookup_lru_fill: fully associative TLB with oldest-entry refill
// Translates one virtual address per item, refilling from the carried page
// table entry on a miss and reporting a fault when that entry is invalid.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one request item per handshake. tdata carries the
//   virtual address and the physical page of the page table entry, tuser
//   carries the page table entry valid flag.
//   Output stream m_axis: one result item per request, in request order.
//   tdata carries the physical address (zero on a fault), tuser the status
//   (hit, miss filled, fault).
//   An accepted item is held in the request register; then lookup, victim
//   choice and entry update run in a single combinational pass into the
//   result register, which drives m_axis_tvalid.
//   The block takes one item per cycle while the receiver does not stall;
//   the TLB entry update of one item is written at the same edge its
//   result is registered, so the next item sees it directly.
//   Reset clears all entries to invalid with age 3 and empties both stages.
//   When the receiver stalls, the result register holds its item and the
//   request register can still take one more item before s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
module tlb_lookup_lru_fill #(
    parameter int TLB_ENTRIES = tlb_lru_pkg::TLB_ENTRIES_DEF,
    parameter int OFFSET_BITS = tlb_lru_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] virt_addr, [19:16] pte_physical_page, [23:20] zero
    input  logic [tlb_lru_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] pte_valid
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] phys_addr
    output logic [tlb_lru_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [tlb_lru_pkg::STAT_W-1:0]    m_axis_tuser
);

    localparam int ADDR_W  = tlb_lru_pkg::ADDR_W;
    localparam int PPAGE_W = tlb_lru_pkg::PPAGE_W;
    localparam int AGE_W   = tlb_lru_pkg::AGE_W;
    localparam int PAGE_W  = ADDR_W - OFFSET_BITS;
    localparam int IDX_W   = $clog2(TLB_ENTRIES);
    localparam int EXT_W   = ADDR_W + PPAGE_W;

    // request register
    logic                   s1_valid_reg;
    logic [ADDR_W-1:0]      s1_va_reg;
    logic                   s1_pte_valid_reg;
    logic [PPAGE_W-1:0]     s1_pte_page_reg;

    // result register
    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      out_pa_reg;
    tlb_lru_pkg::status_t   out_status_reg;
    logic [ADDR_W-1:0]      out_pa_next;
    tlb_lru_pkg::status_t   out_status_next;

    // tlb entries
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;
    logic [PAGE_W-1:0]      vpage_reg [TLB_ENTRIES];
    logic [PAGE_W-1:0]      vpage_next [TLB_ENTRIES];
    logic [PPAGE_W-1:0]     ppage_reg [TLB_ENTRIES];
    logic [PPAGE_W-1:0]     ppage_next [TLB_ENTRIES];
    logic [AGE_W-1:0]       age_reg [TLB_ENTRIES];
    logic [AGE_W-1:0]       age_next [TLB_ENTRIES];

    // lookup signals
    logic                   advance;
    logic [PAGE_W-1:0]      req_page;
    logic [OFFSET_BITS-1:0] req_offset;
    logic [TLB_ENTRIES-1:0] hit_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [AGE_W-1:0]       oldest_age;
    logic [IDX_W-1:0]       victim_idx;
    logic [IDX_W-1:0]       use_idx;
    logic                   do_update;
    logic [PPAGE_W-1:0]     ppage_sel;
    logic [EXT_W-1:0]       pa_ext;

    // handshake: result stage moves when empty or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;

    assign req_page   = s1_va_reg[ADDR_W-1:OFFSET_BITS];
    assign req_offset = s1_va_reg[OFFSET_BITS-1:0];

    // tag compare and lowest matching index
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (vpage_reg[i] == req_page);
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
        hit = |hit_vec;
    end

    // victim: greatest age, lowest index on ties
    always_comb
    begin
        logic [(1 << AGE_W)-1:0] age_seen;
        age_seen   = '0;
        oldest_age = '0;
        victim_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            age_seen[age_reg[i]] = 1'b1;
        end
        for (int a = 0; a < (1 << AGE_W); a++)
        begin
            if (age_seen[a])
            begin
                oldest_age = AGE_W'(a);
            end
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (age_reg[i] == oldest_age)
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    assign use_idx   = hit ? hit_idx : victim_idx;
    assign do_update = s1_valid_reg && advance && (hit || s1_pte_valid_reg);
    assign ppage_sel = hit ? ppage_reg[hit_idx] : s1_pte_page_reg;
    assign pa_ext    = EXT_W'({ppage_sel, req_offset});

    // result formation
    always_comb
    begin
        if (hit)
        begin
            out_status_next = tlb_lru_pkg::STATUS_HIT;
            out_pa_next     = pa_ext[ADDR_W-1:0];
        end
        else if (s1_pte_valid_reg)
        begin
            out_status_next = tlb_lru_pkg::STATUS_FILL;
            out_pa_next     = pa_ext[ADDR_W-1:0];
        end
        else
        begin
            out_status_next = tlb_lru_pkg::STATUS_FAULT;
            out_pa_next     = '0;
        end
    end

    // entry fill and aging
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            vpage_next[i] = vpage_reg[i];
            ppage_next[i] = ppage_reg[i];
            age_next[i]   = age_reg[i];
            if (do_update)
            begin
                if (IDX_W'(i) == use_idx)
                begin
                    age_next[i] = '0;
                    if (!hit)
                    begin
                        valid_next[i] = 1'b1;
                        vpage_next[i] = req_page;
                        ppage_next[i] = s1_pte_page_reg;
                    end
                end
                else if (age_reg[i] != tlb_lru_pkg::AGE_MAX)
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
    end

    // entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                vpage_reg[i] <= '0;
                ppage_reg[i] <= '0;
                age_reg[i]   <= tlb_lru_pkg::AGE_MAX;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                vpage_reg[i] <= vpage_next[i];
                ppage_reg[i] <= ppage_next[i];
                age_reg[i]   <= age_next[i];
            end
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_va_reg        <= s_axis_tdata[ADDR_W-1:0];
            s1_pte_page_reg  <= s_axis_tdata[ADDR_W +: PPAGE_W];
            s1_pte_valid_reg <= s_axis_tuser;
        end
        if (advance && s1_valid_reg)
        begin
            out_pa_reg     <= out_pa_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pa_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// ===== src/tlb_lru_checker.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_checker: port-level checks for the TLB lookup block
// Watches the stream ports for result stability, fault data, latency and input stalls.
// ----------------------------------------------------------------------------
module tlb_lru_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [tlb_lru_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tlb_lru_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic [tlb_lru_pkg::STAT_W-1:0]    m_axis_tuser
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // a fault carries a zero address
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == tlb_lru_pkg::STATUS_FAULT) |->
            m_axis_tdata == '0)
        else $error("fault item with nonzero address");

    // an accepted item is followed by a valid output item once it has passed the request and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("no result item after accepted request");

    // a draining receiver never blocks the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind tlb_lookup_lru_fill tlb_lru_checker u_tlb_lru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tlb_xlate_checker.sv =====
// ----------------------------------------------------------------------------
// tlb_xlate_checker: translation predictor and result checker
// Watches both streams of the TLB block, predicts the translation of every
// accepted request from its own copy of the entries and compares each result.
// ----------------------------------------------------------------------------
module tlb_xlate_checker
    import tlb_lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_DATA_W-1:0]  m_axis_tdata,
    input  logic [STAT_W-1:0]    m_axis_tuser,
    output int                   pending,
    output int                   fails
);

    localparam int ENTRIES  = TLB_ENTRIES_DEF;
    localparam int OFS_BITS = OFFSET_BITS_DEF;
    localparam int VPAGE_W  = ADDR_W - OFS_BITS;
    localparam int OFS_MASK = (1 << OFS_BITS) - 1;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        status_t           status;
    } xlate_t;

    // model copy of the tlb entries
    logic               tlb_valid [ENTRIES];
    logic [VPAGE_W-1:0] tlb_vpage [ENTRIES];
    logic [PPAGE_W-1:0] tlb_ppage [ENTRIES];
    logic [AGE_W-1:0]   tlb_age   [ENTRIES];

    xlate_t expected_xlate[$];

    // used entry goes to age 0, the rest age up to the limit
    function automatic void age_entries(input int used);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i == used)
                tlb_age[i] = '0;
            else if (tlb_age[i] < AGE_MAX)
                tlb_age[i] = tlb_age[i] + 1'b1;
        end
    endfunction

    // translate one request and update the entries
    function automatic xlate_t translate_request(input logic [ADDR_W-1:0] va,
                                                 input logic pte_ok,
                                                 input logic [PPAGE_W-1:0] pte_page);
        xlate_t             res;
        logic [VPAGE_W-1:0] page;
        int                 hit_idx;
        int                 victim;
        page    = va[ADDR_W-1:OFS_BITS];
        hit_idx = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_idx < 0 && tlb_valid[i] && tlb_vpage[i] == page)
                hit_idx = i;
        end
        if (hit_idx >= 0)
        begin
            res.phys_addr = ADDR_W'((int'(tlb_ppage[hit_idx]) << OFS_BITS)
                                    | (int'(va) & OFS_MASK));
            res.status    = STATUS_HIT;
            age_entries(hit_idx);
        end
        else if (!pte_ok)
        begin
            // fault leaves entries and ages alone
            res.phys_addr = '0;
            res.status    = STATUS_FAULT;
        end
        else
        begin
            // oldest entry, lowest index on ties
            victim = 0;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (tlb_age[i] > tlb_age[victim])
                    victim = i;
            end
            tlb_valid[victim] = 1'b1;
            tlb_vpage[victim] = page;
            tlb_ppage[victim] = pte_page;
            age_entries(victim);
            res.phys_addr = ADDR_W'((int'(pte_page) << OFS_BITS) | (int'(va) & OFS_MASK));
            res.status    = STATUS_FILL;
        end
        return res;
    endfunction

    assign pending = expected_xlate.size();

    // predict on request accept, compare on result accept
    always @(posedge clk or negedge rst_n)
    begin
        xlate_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tlb_valid[i] = 1'b0;
                tlb_vpage[i] = '0;
                tlb_ppage[i] = '0;
                tlb_age[i]   = AGE_MAX;
            end
            expected_xlate.delete();
            fails = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_xlate.push_back(translate_request(s_axis_tdata[ADDR_W-1:0],
                                                           s_axis_tuser,
                                                           s_axis_tdata[ADDR_W +: PPAGE_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_xlate.size() == 0)
                begin
                    $error("result item with no request waiting: data %h status %0d",
                           m_axis_tdata, m_axis_tuser);
                    fails++;
                end
                else
                begin
                    want = expected_xlate.pop_front();
                    if (m_axis_tdata !== want.phys_addr)
                    begin
                        $error("phys_addr: expected %h, actual %h",
                               want.phys_addr, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the TLB lookup block
// Drives directed and random translation requests, in bursts or back to back,
// to a ready or stalling receiver; the checker predicts and checks every result.
// ----------------------------------------------------------------------------
module tb;
    import tlb_lru_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 250;
    localparam int WS_PAGES     = 6;

    // receiver stall modes
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;

    int       pending;
    int       fails;
    int       cycles = 0;
    int       burst_left = 0;
    logic     tx_bursty = 1'b1;
    rx_mode_t rx_mode = RX_RANDOM;
    logic [3:0] rx_phase = '0;
    logic [3:0] work_set [WS_PAGES];

    tlb_lookup_lru_fill dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlb_xlate_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending       (pending),
        .fails         (fails)
    );

    // clock
    always #10 clk = ~clk;

    // receiver stall pattern
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1'b1;
        case (rx_mode)
            RX_ALWAYS:  m_axis_tready <= 1'b1;
            RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: m_axis_tready <= (rx_phase < 4'd5) || ($urandom_range(0, 7) == 0);
            default:    m_axis_tready <= 1'b1;
        endcase
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // send one request item; a new burst may open after a random gap
    task automatic send_request(input logic [ADDR_W-1:0] va, input logic pte_ok,
                                input logic [PPAGE_W-1:0] pte_page);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (!tx_bursty || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-ADDR_W-PPAGE_W){1'b0}}, pte_page, va};
        s_axis_tuser  <= pte_ok;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // random request: mostly a small working set, sometimes any address
    task automatic send_random;
        logic [ADDR_W-1:0] va;
        va = ADDR_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            va[ADDR_W-1 -: 4] = work_set[$urandom_range(0, WS_PAGES-1)];
        send_request(va, $urandom_range(0, 9) != 0, PPAGE_W'($urandom_range(0, 15)));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: faults on an empty tlb, fills in index order, hits that
        // ignore the page table entry, oldest-entry refill, extremes
        send_request(16'h0000, 1'b0, 4'h0);
        send_request(16'h0FFF, 1'b1, 4'hF);
        send_request(16'h0ABC, 1'b0, 4'h0);
        send_request(16'h0123, 1'b1, 4'h7);
        send_request(16'hFFFF, 1'b1, 4'h0);
        send_request(16'h7000, 1'b0, 4'hF);
        send_request(16'h1800, 1'b1, 4'hA);
        send_request(16'h2001, 1'b1, 4'h5);
        send_request(16'h3FFE, 1'b1, 4'h3);
        send_request(16'h0555, 1'b1, 4'h9);
        send_request(16'hF00F, 1'b0, 4'h1);
        send_request(16'h1FFF, 1'b0, 4'h0);
        send_request(16'h2000, 1'b1, 4'hF);
        send_request(16'h8421, 1'b1, 4'hF);
        send_request(16'hFFFF, 1'b1, 4'hF);
        send_request(16'hFFFF, 1'b0, 4'h0);

        // random phases with different idle behavior
        for (int p = 0; p < 4; p++)
        begin
            tx_bursty = (p == 1 || p == 2);
            rx_mode  <= (p == 0) ? RX_ALWAYS : (p == 1) ? RX_RANDOM : RX_PATTERN;
            for (int i = 0; i < WS_PAGES; i++)
                work_set[i] = 4'($urandom_range(0, 15));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
        end
        s_axis_tvalid <= 1'b0;
        rx_mode <= RX_RANDOM;

        // drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
